/* rtl/spg_pkg.sv */
// Shared types and codes for the trapezoid-ramp step pulse generator.
`timescale 1ns / 1ps

package spg_pkg;

  // command codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // ramp phases
  localparam logic [1:0] PH_STOP   = 2'd0;
  localparam logic [1:0] PH_ACCEL  = 2'd1;
  localparam logic [1:0] PH_STEADY = 2'd2;
  localparam logic [1:0] PH_DECEL  = 2'd3;

  // register map, index = paddr[3:2]
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_MAX_DELAY  = 2'd0;
  localparam logic [1:0] REG_ACCEL_STEP = 2'd1;
  localparam logic [1:0] REG_UPD_INTVL  = 2'd2;

  localparam logic [31:0] MAX_DELAY_RST  = 32'd1500;
  localparam logic [15:0] ACCEL_STEP_RST = 16'd10;
  localparam logic [31:0] UPD_INTVL_RST  = 32'd2000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_us;
    logic signed [31:0] step_count;
    logic [31:0] target_delay_us;
  } cmd_item_t;

  typedef struct packed {
    logic        step_pulse;
    logic        direction_neg;
    logic        moving;
    logic [1:0]  ramp_phase;
    logic signed [31:0] position;
    logic        start_rejected;
  } res_item_t;

  typedef struct packed {
    logic [31:0] max_delay_us;
    logic [15:0] accel_step_us;
    logic [31:0] update_interval_us;
  } cfg_t;

endpackage

/* rtl/spg_cfg_regs.sv */
// APB register file holding the ramp configuration.
`timescale 1ns / 1ps

module spg_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output spg_pkg::cfg_t              cfg
);
  import spg_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_delay_us       <= MAX_DELAY_RST;
      cfg.accel_step_us      <= ACCEL_STEP_RST;
      cfg.update_interval_us <= UPD_INTVL_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_DELAY:  cfg.max_delay_us       <= pwdata;
        REG_ACCEL_STEP: cfg.accel_step_us      <= pwdata[15:0];
        REG_UPD_INTVL:  cfg.update_interval_us <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_DELAY:  prdata = cfg.max_delay_us;
      REG_ACCEL_STEP: prdata = {16'd0, cfg.accel_step_us};
      REG_UPD_INTVL:  prdata = cfg.update_interval_us;
      default:        prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/spg_ramp_core.sv */
// Motion state registers and the single-pass next-state logic for one item.
`timescale 1ns / 1ps

module spg_ramp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  spg_pkg::cmd_item_t cmd,
  input  spg_pkg::cfg_t      cfg,
  output spg_pkg::res_item_t res
);
  import spg_pkg::*;

  logic [31:0] last_pulse_time, last_pulse_time_next;
  logic [31:0] speed_update_time, speed_update_time_next;
  logic [31:0] steps_remaining, steps_remaining_next;
  logic [31:0] accel_step_count, accel_step_count_next;
  logic [31:0] current_delay, current_delay_next;
  logic [31:0] cruise_delay, cruise_delay_next;
  logic [1:0]  phase_reg, phase_reg_next;
  logic        moving_flag, moving_flag_next;
  logic        negative_dir, negative_dir_next;
  logic [31:0] axis_position, axis_position_next;

  logic [31:0] elapsed_pulse, elapsed_upd, accel_ext;
  logic [31:0] delay_dec, delay_inc;
  logic [32:0] delay_sum;
  logic        update_due, above_cruise, below_cruise;
  logic        fire_cur, fire_cruise, fire_dec, fire_inc;
  logic [31:0] delay_mid, sut_mid;
  logic [1:0]  phase_mid;
  logic        fire;
  logic [31:0] steps_dec, accel_inc;
  logic        near_end, near_end_acc;
  logic        pulse, rejected;

  // all candidates are formed side by side, the phase picks one
  assign elapsed_pulse = cmd.now_us - last_pulse_time;
  assign elapsed_upd   = cmd.now_us - speed_update_time;
  assign update_due    = elapsed_upd > cfg.update_interval_us;
  assign accel_ext     = {16'd0, cfg.accel_step_us};
  assign delay_dec     = (current_delay > accel_ext) ? (current_delay - accel_ext) : 32'd0;
  assign delay_sum     = {1'b0, current_delay} + {1'b0, accel_ext};
  assign delay_inc     = delay_sum[32] ? 32'hFFFF_FFFF : delay_sum[31:0];
  assign above_cruise  = current_delay > cruise_delay;
  assign below_cruise  = current_delay < cruise_delay;
  assign fire_cur      = elapsed_pulse > current_delay;
  assign fire_cruise   = elapsed_pulse > cruise_delay;
  assign fire_dec      = elapsed_pulse > delay_dec;
  assign fire_inc      = elapsed_pulse > delay_inc;
  assign steps_dec     = steps_remaining - 32'd1;
  assign accel_inc     = accel_step_count + 32'd1;
  assign near_end      = steps_dec <= accel_step_count;
  assign near_end_acc  = steps_dec <= accel_inc;

  // interval and phase after the speed update of a tick
  always_comb begin
    delay_mid = current_delay;
    sut_mid   = speed_update_time;
    phase_mid = phase_reg;
    fire      = fire_cur;
    case (phase_reg)
      PH_ACCEL: begin
        if (above_cruise) begin
          if (update_due) begin
            delay_mid = delay_dec;
            sut_mid   = cmd.now_us;
            fire      = fire_dec;
          end
        end else begin
          delay_mid = cruise_delay;
          phase_mid = PH_STEADY;
          fire      = fire_cruise;
        end
      end
      PH_DECEL: begin
        if (below_cruise) begin
          if (update_due) begin
            delay_mid = delay_inc;
            sut_mid   = cmd.now_us;
            fire      = fire_inc;
          end
        end else begin
          delay_mid = cruise_delay;
          fire      = fire_cruise;
        end
      end
      PH_STEADY: begin
        delay_mid = cruise_delay;
        fire      = fire_cruise;
      end
      default: ;
    endcase
  end

  always_comb begin
    last_pulse_time_next   = last_pulse_time;
    speed_update_time_next = speed_update_time;
    steps_remaining_next   = steps_remaining;
    accel_step_count_next  = accel_step_count;
    current_delay_next     = current_delay;
    cruise_delay_next      = cruise_delay;
    phase_reg_next         = phase_reg;
    moving_flag_next       = moving_flag;
    negative_dir_next      = negative_dir;
    axis_position_next     = axis_position;
    pulse                  = 1'b0;
    rejected               = 1'b0;
    case (cmd.operation)
      OP_TICK: begin
        if (moving_flag) begin
          speed_update_time_next = sut_mid;
          current_delay_next     = delay_mid;
          phase_reg_next         = phase_mid;
          if (fire) begin
            last_pulse_time_next = cmd.now_us;
            if (steps_remaining != 32'd0) begin
              pulse                = 1'b1;
              steps_remaining_next = steps_dec;
              if (phase_mid == PH_ACCEL) begin
                accel_step_count_next = accel_inc;
              end
              axis_position_next = negative_dir ? (axis_position - 32'd1)
                                                : (axis_position + 32'd1);
              if ((phase_mid == PH_ACCEL) ? near_end_acc : near_end) begin
                phase_reg_next    = PH_DECEL;
                cruise_delay_next = cfg.max_delay_us;
              end
            end else begin
              moving_flag_next = 1'b0;
              phase_reg_next   = PH_STOP;
            end
          end
        end
      end
      OP_START: begin
        if (moving_flag) begin
          rejected = 1'b1;
        end else begin
          negative_dir_next     = cmd.step_count[31];
          steps_remaining_next  = cmd.step_count[31] ? (32'd0 - cmd.step_count)
                                                     : cmd.step_count;
          cruise_delay_next     = cmd.target_delay_us;
          current_delay_next    = cfg.max_delay_us;
          accel_step_count_next = 32'd0;
          moving_flag_next      = 1'b1;
          phase_reg_next        = PH_ACCEL;
        end
      end
      OP_STOP: begin
        moving_flag_next = 1'b0;
        phase_reg_next   = PH_STOP;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.step_pulse     = pulse;
    res.direction_neg  = negative_dir_next;
    res.moving         = moving_flag_next;
    res.ramp_phase     = phase_reg_next;
    res.position       = axis_position_next;
    res.start_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_time   <= 32'd0;
      speed_update_time <= 32'd0;
      steps_remaining   <= 32'd0;
      accel_step_count  <= 32'd0;
      current_delay     <= 32'd0;
      cruise_delay      <= 32'd0;
      phase_reg         <= PH_STOP;
      moving_flag       <= 1'b0;
      negative_dir      <= 1'b0;
      axis_position     <= 32'd0;
    end else if (en) begin
      last_pulse_time   <= last_pulse_time_next;
      speed_update_time <= speed_update_time_next;
      steps_remaining   <= steps_remaining_next;
      accel_step_count  <= accel_step_count_next;
      current_delay     <= current_delay_next;
      cruise_delay      <= cruise_delay_next;
      phase_reg         <= phase_reg_next;
      moving_flag       <= moving_flag_next;
      negative_dir      <= negative_dir_next;
      axis_position     <= axis_position_next;
    end
  end

endmodule

/* rtl/stepper_trapezoid_pulse_gen.sv */
// Top level: command register, ramp core, result register and APB registers.
//
//  channel | signals                            | payload
//  --------+------------------------------------+------------------
//  cmd     | cmd_valid in, cmd_stall out        | cmd_item_t
//  res     | res_valid out, res_stall in        | res_item_t
//  apb     | psel penable pwrite paddr pwdata   | prdata, pready=1
//
// One item per cycle while the result is not stalled: an item is held in the
// command register, and the motion state is updated as it moves into the
// result register, which then raises res_valid.
// rst is synchronous, active high; it clears motion state and loads
// register defaults. A stalled result holds; one more item is taken
// into the command register behind it, then cmd_stall rises.
`timescale 1ns / 1ps

module stepper_trapezoid_pulse_gen (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  spg_pkg::cmd_item_t         cmd,
  output logic                       res_valid,
  input  logic                       res_stall,
  output spg_pkg::res_item_t         res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import spg_pkg::*;

  cfg_t      cfg;
  cmd_item_t cmd_q;
  logic      cmd_q_valid;
  res_item_t res_comb;
  logic      advance, accept;

  spg_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance   = cmd_q_valid && (!res_valid || !res_stall);
  assign cmd_stall = cmd_q_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (accept) begin
      cmd_q_valid <= 1'b1;
    end else if (advance) begin
      cmd_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
  end

  spg_ramp_core u_core (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .cmd (cmd_q),
    .cfg (cfg),
    .res (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

`ifndef ASSERT_OFF
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("result register not loaded after advance");

  a_moving_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.moving == (res.ramp_phase != PH_STOP)))
    else $error("moving flag disagrees with ramp phase");

  a_pulse_moving: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.step_pulse || res.start_rejected)) |-> res.moving)
    else $error("step or rejection reported while not moving");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (cmd_q_valid && res_valid && res_stall))
    else $error("command stalled with room downstream");
`endif

endmodule
